// ===== rtl/rwcp_pkg.sv =====
`timescale 1ns / 1ps

package rwcp_pkg;

	// Chunk and form tags, most significant byte first as they appear in the file.
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] NO_FORMAT = 16'hFFFF;
	localparam logic [127:0] FMT_RESET = {112'd0, NO_FORMAT};

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd1;
	localparam logic [2:0] ERR_NOT_WAVE    = 3'd2;
	localparam logic [2:0] ERR_SHORT_HDR   = 3'd3;
	localparam logic [2:0] ERR_OVERRUN     = 3'd4;
	localparam logic [2:0] ERR_FMT_SHORT   = 3'd5;
	localparam logic [2:0] ERR_UNSUPPORTED = 3'd6;

	localparam int RESULT_DEPTH = 4;

	typedef struct packed {
		logic [1:0]   kind;
		logic [7:0]   data;
		logic [127:0] fmt;
		logic [2:0]   err;
		logic         last;
	} result_t;

endpackage

// ===== rtl/riff_wave_chunk_parser.sv =====
`timescale 1ns / 1ps

// RIFF WAVE chunk parser.
// Input channel (byte_valid/byte_ready, in_byte, in_last) carries one file byte
// per beat; in_last marks the final byte of the buffer.
// Result channel (result_valid/result_ready) carries data bytes of 'data'
// chunks, then one format summary or error with last set.
// Each beat is parsed in the cycle it is accepted; its results are written
// into a small result queue of RESULT_DEPTH entries and leave it in order
// through the result ports. One input beat is taken every cycle as long as the
// queue has room for two more results, since a beat can cause up to two
// (a data byte plus the final result). With a receiver that takes a result
// every cycle the rate is one byte per cycle.
// When the receiver stalls, the queue fills and byte_ready drops once fewer
// than two entries are free; nothing is lost or reordered.
// After in_last all parser state returns to its reset values for the next file.
// Reset (arst_n low) clears the parser state and empties the queue.
module riff_wave_chunk_parser #(
	parameter int RESULT_DEPTH = rwcp_pkg::RESULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  data_byte,
	output logic [15:0] format_code,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] bits_per_sample,
	output logic [2:0]  error_code,
	output logic        last
);
	import rwcp_pkg::*;

	localparam int PTR_W = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
	localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_CHUNKHDR = 3'd1;
	localparam logic [2:0] PH_FMT      = 3'd2;
	localparam logic [2:0] PH_DATA     = 3'd3;
	localparam logic [2:0] PH_SKIP     = 3'd4;
	localparam logic [2:0] PH_WAIT     = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	logic [2:0]   phase_q, phase_n;
	logic [32:0]  pos_q, pos_n;
	logic [32:0]  riff_size_q, riff_size_n;
	logic [31:0]  tag_q, tag_n;
	logic [31:0]  remain_q, remain_n;
	logic [31:0]  shift_q, shift_n;
	logic [127:0] fmt_q, fmt_n;
	logic         err_seen_q, err_seen_n;
	logic [2:0]   err_num_q, err_num_n;

	result_t fifo_q [RESULT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic        accept, pop;
	logic [33:0] next_pos, file_end, hdr_sum;
	logic        end_reached, hdr_short;
	logic [31:0] fmt_idx;
	result_t     res_first, res_end, res_a, res_b;
	logic        first_v, end_v;
	logic [1:0]  push_cnt;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RESULT_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign accept = byte_valid && byte_ready;
	assign pop = result_valid && result_ready;
	assign byte_ready = (count_q <= CNT_W'(RESULT_DEPTH - 2));
	assign result_valid = (count_q != '0);

	assign next_pos = {1'b0, pos_q} + 34'd1;
	assign file_end = (riff_size_q < 33'd12) ? 34'd12 : {1'b0, riff_size_q};
	assign end_reached = (next_pos >= file_end);
	// Valid only when the end is not yet reached.
	assign hdr_short = ((file_end - next_pos) < 34'd8);
	assign fmt_idx = shift_q - remain_q;

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		riff_size_n = riff_size_q;
		tag_n = tag_q;
		remain_n = remain_q;
		shift_n = shift_q;
		fmt_n = fmt_q;
		err_seen_n = err_seen_q;
		err_num_n = err_num_q;
		hdr_sum = '0;
		first_v = 1'b0;
		end_v = 1'b0;
		res_first = '0;
		res_end = '0;

		if (phase_q != PH_DONE) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q < 33'd4) begin
						shift_n = {shift_q[23:0], in_byte};
						if (pos_q == 33'd3 && shift_n != TAG_RIFF) begin
							first_v = 1'b1;
							res_first.kind = KIND_ERROR;
							res_first.err = ERR_NOT_RIFF;
							res_first.last = 1'b1;
							phase_n = PH_DONE;
						end
					end else if (pos_q < 33'd8) begin
						shift_n = {in_byte, shift_q[31:8]};
						if (pos_q == 33'd7) begin
							riff_size_n = {1'b0, shift_n} + 33'd8;
						end
					end else begin
						tag_n = {tag_q[23:0], in_byte};
						if (pos_q == 33'd11) begin
							if (tag_n != TAG_WAVE) begin
								err_seen_n = 1'b1;
								err_num_n = ERR_NOT_WAVE;
								phase_n = PH_WAIT;
							end else if (end_reached) begin
								phase_n = PH_WAIT;
							end else if (hdr_short) begin
								err_seen_n = 1'b1;
								err_num_n = ERR_SHORT_HDR;
								phase_n = PH_WAIT;
							end else begin
								phase_n = PH_CHUNKHDR;
								remain_n = 32'd8;
							end
						end
					end
				end
				PH_CHUNKHDR: begin
					if (remain_q > 32'd4) begin
						tag_n = {tag_q[23:0], in_byte};
					end else begin
						shift_n = {in_byte, shift_q[31:8]};
					end
					remain_n = remain_q - 32'd1;
					if (remain_n == '0) begin
						hdr_sum = next_pos + {2'b00, shift_n};
						if (hdr_sum > file_end) begin
							err_seen_n = 1'b1;
							err_num_n = ERR_OVERRUN;
							phase_n = PH_WAIT;
						end else if (tag_q == TAG_FMT && shift_n < 32'd16) begin
							err_seen_n = 1'b1;
							err_num_n = ERR_FMT_SHORT;
							phase_n = PH_WAIT;
						end else begin
							if (tag_q == TAG_FMT) begin
								phase_n = PH_FMT;
							end else if (tag_q == TAG_DATA) begin
								phase_n = PH_DATA;
							end else begin
								phase_n = PH_SKIP;
							end
							remain_n = shift_n;
							// An empty chunk moves straight on to the next header.
							if (shift_n == '0) begin
								if (end_reached) begin
									phase_n = PH_WAIT;
								end else if (hdr_short) begin
									err_seen_n = 1'b1;
									err_num_n = ERR_SHORT_HDR;
									phase_n = PH_WAIT;
								end else begin
									phase_n = PH_CHUNKHDR;
									remain_n = 32'd8;
								end
							end
						end
					end
				end
				PH_FMT, PH_DATA, PH_SKIP: begin
					if (phase_q == PH_FMT) begin
						if (fmt_idx[31:4] == '0) begin
							for (int i = 0; i < 16; i++) begin
								if (fmt_idx[3:0] == 4'(i)) begin
									fmt_n[8*i +: 8] = in_byte;
								end
							end
						end
					end else if (phase_q == PH_DATA) begin
						first_v = 1'b1;
						res_first.kind = KIND_DATA;
						res_first.data = in_byte;
					end
					if (remain_q != '0) begin
						remain_n = remain_q - 32'd1;
					end
					if (remain_n == '0) begin
						if (end_reached) begin
							phase_n = PH_WAIT;
						end else if (hdr_short) begin
							err_seen_n = 1'b1;
							err_num_n = ERR_SHORT_HDR;
							phase_n = PH_WAIT;
						end else begin
							phase_n = PH_CHUNKHDR;
							remain_n = 32'd8;
						end
					end
				end
				default: begin
				end
			endcase

			pos_n = next_pos[32:0];

			if (phase_n != PH_DONE && pos_q >= 33'd11 && end_reached) begin
				end_v = 1'b1;
				res_end.last = 1'b1;
				if (err_seen_n) begin
					res_end.kind = KIND_ERROR;
					res_end.err = err_num_n;
				end else if (fmt_n[15:0] == 16'd1 || fmt_n[15:0] == 16'd2) begin
					res_end.kind = KIND_SUMMARY;
					res_end.fmt = fmt_n;
				end else begin
					res_end.kind = KIND_ERROR;
					res_end.err = ERR_UNSUPPORTED;
				end
				phase_n = PH_DONE;
			end

			if (in_last && phase_n != PH_DONE) begin
				end_v = 1'b1;
				res_end.kind = KIND_ERROR;
				res_end.err = ERR_TRUNCATED;
				res_end.last = 1'b1;
			end
		end

		if (in_last) begin
			phase_n = PH_HEADER;
			pos_n = '0;
			riff_size_n = '0;
			tag_n = '0;
			remain_n = '0;
			shift_n = '0;
			fmt_n = FMT_RESET;
			err_seen_n = 1'b0;
			err_num_n = '0;
		end
	end

	// A beat makes at most two results; the early one always goes first.
	assign res_a = first_v ? res_first : res_end;
	assign res_b = res_end;
	assign push_cnt = {1'b0, first_v} + {1'b0, end_v};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			riff_size_q <= '0;
			tag_q <= '0;
			remain_q <= '0;
			shift_q <= '0;
			fmt_q <= FMT_RESET;
			err_seen_q <= 1'b0;
			err_num_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			riff_size_q <= riff_size_n;
			tag_q <= tag_n;
			remain_q <= remain_n;
			shift_q <= shift_n;
			fmt_q <= fmt_n;
			err_seen_q <= err_seen_n;
			err_num_q <= err_num_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				if (push_cnt == 2'd1) begin
					wr_ptr_q <= ptr_inc(wr_ptr_q);
				end else if (push_cnt == 2'd2) begin
					wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
				end
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + (accept ? CNT_W'(push_cnt) : '0) - (pop ? CNT_W'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push_cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_a;
			if (push_cnt == 2'd2) begin
				fifo_q[ptr_inc(wr_ptr_q)] <= res_b;
			end
		end
	end

	assign out_kind = fifo_q[rd_ptr_q].kind;
	assign data_byte = fifo_q[rd_ptr_q].data;
	assign format_code = fifo_q[rd_ptr_q].fmt[15:0];
	assign channel_count = fifo_q[rd_ptr_q].fmt[31:16];
	assign sample_rate = fifo_q[rd_ptr_q].fmt[63:32];
	assign byte_rate = fifo_q[rd_ptr_q].fmt[95:64];
	assign block_align = fifo_q[rd_ptr_q].fmt[111:96];
	assign bits_per_sample = fifo_q[rd_ptr_q].fmt[127:112];
	assign error_code = fifo_q[rd_ptr_q].err;
	assign last = fifo_q[rd_ptr_q].last;

endmodule

// ===== bench/wave_parse_checker.sv =====
`timescale 1ns / 1ps

module wave_parse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [1:0]  out_kind,
	input  logic [7:0]  data_byte,
	input  logic [15:0] format_code,
	input  logic [15:0] channel_count,
	input  logic [31:0] sample_rate,
	input  logic [31:0] byte_rate,
	input  logic [15:0] block_align,
	input  logic [15:0] bits_per_sample,
	input  logic [2:0]  error_code,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          data_beats,
	output int          summary_beats,
	output int          error_beats
);
	import rwcp_pkg::*;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_CHUNK_HDR,
		ST_FMT,
		ST_DATA,
		ST_SKIP,
		ST_WAIT,
		ST_DONE
	} parse_state_t;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] fcode;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [31:0] brate;
		logic [15:0] align;
		logic [15:0] depth;
		logic [2:0]  code;
		logic        fin;
	} wave_result_t;

	parse_state_t pstate;
	bit [63:0]    file_pos;
	bit [63:0]    riff_end;
	bit [63:0]    chunk_left;
	bit [31:0]    shift_reg;
	bit [31:0]    tag_reg;
	bit [7:0]     fmt_bytes [16];
	bit           err_latched;
	bit [2:0]     err_latched_code;

	wave_result_t expected_q [$];
	wave_result_t want;

	int fails = 0;
	int pending_n = 0;
	int n_data = 0;
	int n_summary = 0;
	int n_error = 0;

	assign fail_count = fails;
	assign pending = pending_n;
	assign data_beats = n_data;
	assign summary_beats = n_summary;
	assign error_beats = n_error;

	function automatic void clear_parser();
		pstate = ST_HEADER;
		file_pos = '0;
		riff_end = '0;
		chunk_left = '0;
		shift_reg = '0;
		tag_reg = '0;
		foreach (fmt_bytes[i])
			fmt_bytes[i] = '0;
		fmt_bytes[0] = NO_FORMAT[7:0];
		fmt_bytes[1] = NO_FORMAT[15:8];
		err_latched = 1'b0;
		err_latched_code = '0;
	endfunction

	// A RIFF size under twelve still forces the full 12-byte header to be read.
	function automatic bit [63:0] end_of_file();
		return (riff_end < 64'd12) ? 64'd12 : riff_end;
	endfunction

	function automatic void latch_err(bit [2:0] code);
		err_latched = 1'b1;
		err_latched_code = code;
		pstate = ST_WAIT;
	endfunction

	function automatic void open_chunk(bit [63:0] nxt);
		bit [63:0] fend;
		fend = end_of_file();
		if (nxt >= fend) begin
			pstate = ST_WAIT;
		end else if (fend - nxt < 64'd8) begin
			latch_err(ERR_SHORT_HDR);
		end else begin
			pstate = ST_CHUNK_HDR;
			chunk_left = 64'd8;
		end
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [7:0] dat, logic [2:0] code,
			bit with_fmt);
		wave_result_t r;
		r.kind = kind;
		r.data = dat;
		r.code = code;
		r.fin = (kind != KIND_DATA);
		r.fcode = with_fmt ? {fmt_bytes[1], fmt_bytes[0]} : '0;
		r.chans = with_fmt ? {fmt_bytes[3], fmt_bytes[2]} : '0;
		r.rate = with_fmt ? {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]} : '0;
		r.brate = with_fmt ? {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]} : '0;
		r.align = with_fmt ? {fmt_bytes[13], fmt_bytes[12]} : '0;
		r.depth = with_fmt ? {fmt_bytes[15], fmt_bytes[14]} : '0;
		expected_q.push_back(r);
	endfunction

	function automatic void parse_byte(bit [7:0] b, bit lst);
		bit [63:0] pos;
		bit [63:0] nxt;
		bit [63:0] idx;
		bit [63:0] csize;
		bit [15:0] fcode;
		if (pstate == ST_DONE) begin
			if (lst)
				clear_parser();
			return;
		end
		pos = file_pos;
		nxt = pos + 64'd1;
		case (pstate)
			ST_HEADER: begin
				if (pos < 64'd4) begin
					shift_reg = {shift_reg[23:0], b};
					if (pos == 64'd3 && shift_reg != TAG_RIFF) begin
						push_result(KIND_ERROR, '0, ERR_NOT_RIFF, 1'b0);
						pstate = ST_DONE;
					end
				end else if (pos < 64'd8) begin
					shift_reg = {b, shift_reg[31:8]};
					if (pos == 64'd7)
						riff_end = 64'(shift_reg) + 64'd8;
				end else begin
					tag_reg = {tag_reg[23:0], b};
					if (pos == 64'd11) begin
						if (tag_reg != TAG_WAVE)
							latch_err(ERR_NOT_WAVE);
						else
							open_chunk(nxt);
					end
				end
			end
			ST_CHUNK_HDR: begin
				// Tag comes big-endian, the size little-endian.
				if (chunk_left > 64'd4)
					tag_reg = {tag_reg[23:0], b};
				else
					shift_reg = {b, shift_reg[31:8]};
				chunk_left--;
				if (chunk_left == 64'd0) begin
					csize = 64'(shift_reg);
					if (nxt + csize > end_of_file()) begin
						latch_err(ERR_OVERRUN);
					end else if (tag_reg == TAG_FMT && csize < 64'd16) begin
						latch_err(ERR_FMT_SHORT);
					end else begin
						pstate = (tag_reg == TAG_FMT) ? ST_FMT :
							(tag_reg == TAG_DATA) ? ST_DATA : ST_SKIP;
						chunk_left = csize;
						if (csize == 64'd0)
							open_chunk(nxt);
					end
				end
			end
			ST_FMT, ST_DATA, ST_SKIP: begin
				if (pstate == ST_FMT) begin
					// The chunk size stays in shift_reg while the body streams by.
					idx = 64'(shift_reg) - chunk_left;
					if (idx < 64'd16)
						fmt_bytes[idx[3:0]] = b;
				end else if (pstate == ST_DATA) begin
					push_result(KIND_DATA, b, '0, 1'b0);
				end
				if (chunk_left > 64'd0)
					chunk_left--;
				if (chunk_left == 64'd0)
					open_chunk(nxt);
			end
			default: ;
		endcase

		file_pos = nxt & 64'h1_FFFF_FFFF;

		if (pstate != ST_DONE && pos >= 64'd11 && nxt >= end_of_file()) begin
			fcode = {fmt_bytes[1], fmt_bytes[0]};
			if (err_latched)
				push_result(KIND_ERROR, '0, err_latched_code, 1'b0);
			else if (fcode == 16'd1 || fcode == 16'd2)
				push_result(KIND_SUMMARY, '0, '0, 1'b1);
			else
				push_result(KIND_ERROR, '0, ERR_UNSUPPORTED, 1'b0);
			pstate = ST_DONE;
		end

		if (lst) begin
			if (pstate != ST_DONE)
				push_result(KIND_ERROR, '0, ERR_TRUNCATED, 1'b0);
			clear_parser();
		end
	endfunction

	task automatic report(string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s got %0h, expected %0h", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_q.delete();
			pending_n = 0;
		end else begin
			if (byte_valid && byte_ready)
				parse_byte(in_byte, in_last);
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("result beat of kind %0d with nothing expected", out_kind));
				end else begin
					want = expected_q.pop_front();
					check_field("out_kind", 32'(out_kind), 32'(want.kind));
					check_field("data_byte", 32'(data_byte), 32'(want.data));
					check_field("format_code", 32'(format_code), 32'(want.fcode));
					check_field("channel_count", 32'(channel_count), 32'(want.chans));
					check_field("sample_rate", sample_rate, want.rate);
					check_field("byte_rate", byte_rate, want.brate);
					check_field("block_align", 32'(block_align), 32'(want.align));
					check_field("bits_per_sample", 32'(bits_per_sample), 32'(want.depth));
					check_field("error_code", 32'(error_code), 32'(want.code));
					check_field("last", 32'(last), 32'(want.fin));
					if (want.kind == KIND_DATA)
						n_data++;
					else if (want.kind == KIND_SUMMARY)
						n_summary++;
					else
						n_error++;
				end
			end
			pending_n = expected_q.size();
		end
	end

endmodule

// ===== bench/tb_riff_wave_chunk_parser.sv =====
`timescale 1ns / 1ps

module tb_riff_wave_chunk_parser;
	import rwcp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  out_kind;
	logic [7:0]  data_byte;
	logic [15:0] format_code;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [15:0] block_align;
	logic [15:0] bits_per_sample;
	logic [2:0]  error_code;
	logic        last;

	int fail_count;
	int pending;
	int data_beats;
	int summary_beats;
	int error_beats;

	bit [7:0] file_q [$];
	bit       quiet;
	int       bytes_sent;
	int       files_sent;
	int       guard;

	riff_wave_chunk_parser uut (.*);

	wave_parse_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Run timed out with %0d results still expected.", pending);
		$display("tb_riff_wave_chunk_parser failed");
		$finish;
	end

	always @(negedge clk)
		result_ready <= quiet || ($urandom_range(0, 99) >= 13);

	function automatic void put_tag(bit [31:0] t);
		file_q.push_back(t[31:24]);
		file_q.push_back(t[23:16]);
		file_q.push_back(t[15:8]);
		file_q.push_back(t[7:0]);
	endfunction

	function automatic void put_le(bit [31:0] v, int nbytes);
		for (int i = 0; i < nbytes; i++)
			file_q.push_back(v[8*i +: 8]);
	endfunction

	function automatic void set_le32(int at, bit [31:0] v);
		for (int i = 0; i < 4; i++)
			file_q[at + i] = v[8*i +: 8];
	endfunction

	// Sends the buffered file, in_last on its final beat.
	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++) begin
			@(negedge clk);
			while (!quiet && $urandom_range(0, 99) < 13) begin
				byte_valid <= 1'b0;
				@(negedge clk);
			end
			byte_valid <= 1'b1;
			in_byte <= file_q[i];
			in_last <= (i == file_q.size() - 1);
			@(posedge clk);
			while (!byte_ready)
				@(posedge clk);
			bytes_sent++;
			quiet = (bytes_sent >= 200 && bytes_sent < 330);
		end
		files_sent++;
	endtask

	// Mostly well-formed files with random chunks; about a third are damaged
	// in one way and a few are plain noise.
	task automatic make_random_file();
		int        pick;
		int        flaw;
		int        nck;
		int        ck;
		int        len;
		int        at;
		bit [127:0] img;
		file_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			len = $urandom_range(1, 16);
			repeat (len)
				file_q.push_back(8'($urandom));
			return;
		end
		flaw = (pick < 40) ? $urandom_range(0, 5) : -1;
		put_tag(TAG_RIFF);
		put_le(32'd0, 4);
		put_tag(TAG_WAVE);
		nck = $urandom_range(0, 4);
		for (int c = 0; c < nck; c++) begin
			ck = $urandom_range(0, 2);
			if (c == 0 && $urandom_range(0, 3) != 0)
				ck = 0;
			case (ck)
				0: begin
					if ($urandom_range(0, 7) == 0)
						len = $urandom_range(0, 15);
					else
						len = 16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
					put_tag(TAG_FMT);
					put_le(len, 4);
					img = {$urandom, $urandom, $urandom, $urandom};
					pick = $urandom_range(0, 9);
					if (pick < 5)
						img[15:0] = 16'd1;
					else if (pick < 8)
						img[15:0] = 16'd2;
					if ($urandom_range(0, 1))
						img[31:16] = 16'($urandom_range(1, 8));
					for (int k = 0; k < len; k++)
						file_q.push_back((k < 16) ? img[8*k +: 8] : 8'($urandom));
				end
				1: begin
					len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					put_tag(TAG_DATA);
					put_le(len, 4);
					repeat (len)
						file_q.push_back(8'($urandom));
				end
				default: begin
					len = $urandom_range(0, 8);
					put_tag($urandom_range(0, 1) ? 32'h4C49_5354 : $urandom);
					put_le(len, 4);
					repeat (len)
						file_q.push_back(8'($urandom));
				end
			endcase
		end
		// A stub of under eight bytes where the next chunk header would start.
		if (flaw == 4)
			repeat ($urandom_range(1, 7))
				file_q.push_back(8'($urandom));
		set_le32(4, file_q.size() - 8);
		case (flaw)
			0: begin
				at = $urandom_range(1, file_q.size() - 1);
				while (file_q.size() > at)
					void'(file_q.pop_back());
			end
			1: begin
				at = $urandom_range(0, 11);
				file_q[at] = file_q[at] ^ 8'(1 << $urandom_range(0, 7));
			end
			2: begin
				pick = $urandom_range(0, 2);
				if (pick == 0)
					set_le32(4, $urandom_range(0, 11));
				else if (pick == 1)
					set_le32(4, 32'hFFFF_FFFF);
				else
					set_le32(4, file_q.size() - 8 - $urandom_range(1, 6));
			end
			3: begin
				if (file_q.size() >= 20)
					set_le32(16, $urandom);
			end
			5: file_q[$urandom_range(0, 11)] = 8'($urandom);
			default: ;
		endcase
		// Bytes past the RIFF size are ignored up to in_last.
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4))
				file_q.push_back(8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		in_byte = '0;
		in_last = 1'b0;
		quiet = 1'b0;
		bytes_sent = 0;
		files_sent = 0;
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;

		// Buffer of a single byte, ending inside the magic.
		file_q = {8'h52};
		send_file();
		// Three bytes of the magic, then the buffer ends.
		file_q.delete();
		put_tag(TAG_RIFF);
		void'(file_q.pop_back());
		send_file();
		// Wrong magic, with trailing bytes that must be ignored.
		file_q.delete();
		put_tag({TAG_RIFF[31:8], 8'h58});
		file_q.push_back(8'h00);
		file_q.push_back(8'hFF);
		send_file();
		// RIFF size of zero: only the header is read and no fmt chunk is seen.
		file_q.delete();
		put_tag(TAG_RIFF);
		put_le(32'd0, 4);
		put_tag(TAG_WAVE);
		send_file();

		while (bytes_sent < 520) begin
			if (files_sent == 6 || $urandom_range(0, 7) == 0) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			make_random_file();
			send_file();
		end

		@(negedge clk);
		byte_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20)
			@(negedge clk);

		$display("Streamed %0d bytes in %0d files through the parser.", bytes_sent, files_sent);
		$display("Checked %0d data beats, %0d format summaries and %0d error beats.",
			data_beats, summary_beats, error_beats);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_riff_wave_chunk_parser passed");
		end else begin
			if (pending != 0)
				$display("%0d expected results never arrived.", pending);
			$display("tb_riff_wave_chunk_parser failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rwcp_pkg.sv
rtl/riff_wave_chunk_parser.sv
bench/wave_parse_checker.sv
bench/tb_riff_wave_chunk_parser.sv
